// File: design/htmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htmc_pkg
// Shared types and constants of the hash table match and claim unit.
// ----------------------------------------------------------------------------
package htmc_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BYTES    = 20;
    localparam int KEY_W        = KEY_BYTES * 8;
    localparam int KEY_HIGH_W   = 32;
    localparam int KEY_MID_W    = 64;
    localparam int KEY_LOW_W    = 64;
    localparam int MARK_W       = 2;
    localparam int INDEX_W      = 6;
    localparam int COUNT_W      = 7;
    localparam int MODE_W       = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ANY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MARK  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLAIM = 2'd3;

    localparam logic [MARK_W-1:0] MARK_FREE    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_CLAIMED = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    // Write strobes into the entry store
    typedef struct packed {
        logic key_en;
        logic mark_en;
    } t_store_wr;

endpackage
`default_nettype wire

// File: design/htmc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htmc_store
// Entry store: key memory and mark memory, one write port, one registered
// read port.
// ----------------------------------------------------------------------------
module htmc_store #(
    parameter int CAPACITY = htmc_pkg::CAPACITY_DEF,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire                              i_clk,
    input  htmc_pkg::t_store_wr              i_wr,
    input  wire  [AW-1:0]                    i_wr_addr,
    input  wire  [htmc_pkg::KEY_W-1:0]       i_wr_key,
    input  wire  [htmc_pkg::MARK_W-1:0]      i_wr_mark,
    input  wire  [AW-1:0]                    i_rd_addr,
    output logic [htmc_pkg::KEY_W-1:0]       o_rd_key,
    output logic [htmc_pkg::MARK_W-1:0]      o_rd_mark
);

    logic [htmc_pkg::KEY_W-1:0]  key_mem  [CAPACITY];
    logic [htmc_pkg::MARK_W-1:0] mark_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_wr.key_en) begin
            key_mem[i_wr_addr] <= i_wr_key;
        end
        o_rd_key <= key_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.mark_en) begin
            mark_mem[i_wr_addr] <= i_wr_mark;
        end
        o_rd_mark <= mark_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// File: design/hash_table_match_and_claim_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hash_table_match_and_claim_unit
// Key table with load, find, find-with-mark and claim operations.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one word of mode, 160-bit key,
// entry index and mark. Output channel: o_valid / i_stall carry found,
// match index and match mark, one result word per input word.
// Configuration: i_cfg_wr_en writes entry_count (slots scanned from 0).
// A load writes the store at the accepting edge and goes straight to its
// result word, as does a search while entry_count is 0. A search reads
// one entry per cycle through the single read port of the store and
// stops at the first hit, after comparing 1 to min(entry_count, CAPACITY)
// entries. A claim writes the mark of the hit entry to 2 in the cycle it
// is found. One word is in flight at a time;
// the next word is accepted as soon as the result sits in the output
// register, even while that register is stalled. Reset clears the control
// state and entry_count; the table contents are undefined until loaded.
// While i_stall is high a pending result holds and the next finished
// result waits in the sequencer.
// ----------------------------------------------------------------------------
module hash_table_match_and_claim_unit #(
    parameter int CAPACITY = htmc_pkg::CAPACITY_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire  [htmc_pkg::COUNT_W-1:0]       i_cfg_wr_data,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [htmc_pkg::MODE_W-1:0]        i_mode,
    input  wire  [htmc_pkg::KEY_HIGH_W-1:0]    i_key_high,
    input  wire  [htmc_pkg::KEY_MID_W-1:0]     i_key_mid,
    input  wire  [htmc_pkg::KEY_LOW_W-1:0]     i_key_low,
    input  wire  [htmc_pkg::INDEX_W-1:0]       i_entry_index,
    input  wire  [htmc_pkg::MARK_W-1:0]        i_given_mark,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic                               o_found,
    output logic [htmc_pkg::INDEX_W-1:0]       o_match_index,
    output logic [htmc_pkg::MARK_W-1:0]        o_match_mark
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > htmc_pkg::COUNT_W) ? CW : htmc_pkg::COUNT_W;
    localparam int IW = (AW > htmc_pkg::INDEX_W) ? AW : htmc_pkg::INDEX_W;
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

    htmc_pkg::t_state r_state, n_state;

    logic [htmc_pkg::COUNT_W-1:0] r_entry_count;
    logic [htmc_pkg::MODE_W-1:0]  r_mode;
    logic [htmc_pkg::KEY_W-1:0]   r_key;
    logic [htmc_pkg::MARK_W-1:0]  r_mark;
    logic [AW-1:0]                r_scan_addr, n_scan_addr;
    logic [AW-1:0]                r_cmp_idx, n_cmp_idx;
    logic                         r_res_found, n_res_found;
    logic [htmc_pkg::INDEX_W-1:0] r_res_index, n_res_index;
    logic [htmc_pkg::MARK_W-1:0]  r_res_mark, n_res_mark;
    logic                         r_out_valid;
    logic                         r_out_found;
    logic [htmc_pkg::INDEX_W-1:0] r_out_index;
    logic [htmc_pkg::MARK_W-1:0]  r_out_mark;

    htmc_pkg::t_store_wr          st_wr;
    logic [AW-1:0]                st_wr_addr;
    logic [htmc_pkg::KEY_W-1:0]   st_wr_key;
    logic [htmc_pkg::MARK_W-1:0]  st_wr_mark;
    logic [htmc_pkg::KEY_W-1:0]   st_rd_key;
    logic [htmc_pkg::MARK_W-1:0]  st_rd_mark;

    logic                         in_acc;
    logic                         out_free;
    logic [LW-1:0]                limit;
    logic [IW-1:0]                in_index_w;
    logic                         load_ok;
    logic [htmc_pkg::KEY_W-1:0]   in_key;
    logic                         hit;
    logic                         last;
    logic [IW-1:0]                cmp_idx_w;

    assign in_key     = {i_key_high, i_key_mid, i_key_low};
    assign in_acc     = i_valid && !o_stall;
    assign out_free   = !r_out_valid || !i_stall;
    assign limit      = (LW'(r_entry_count) > CAP_L) ? CAP_L : LW'(r_entry_count);
    assign in_index_w = IW'(i_entry_index);
    assign load_ok    = (LW'(i_entry_index) < CAP_L);
    assign cmp_idx_w  = IW'(r_cmp_idx);

    // Hit on the entry read last cycle; mode 1 ignores the mark
    assign hit  = (st_rd_key == r_key) &&
                  ((r_mode == htmc_pkg::MODE_ANY) || (st_rd_mark == r_mark));
    assign last = ((LW'(r_cmp_idx) + LW'(1)) == limit);

    htmc_store #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (st_wr),
        .i_wr_addr (st_wr_addr),
        .i_wr_key  (st_wr_key),
        .i_wr_mark (st_wr_mark),
        .i_rd_addr (r_scan_addr),
        .o_rd_key  (st_rd_key),
        .o_rd_mark (st_rd_mark)
    );

    always_comb begin
        n_state     = r_state;
        n_scan_addr = r_scan_addr;
        n_cmp_idx   = r_cmp_idx;
        n_res_found = r_res_found;
        n_res_index = r_res_index;
        n_res_mark  = r_res_mark;
        st_wr       = '0;
        st_wr_addr  = in_index_w[AW-1:0];
        st_wr_key   = in_key;
        st_wr_mark  = i_given_mark;
        o_stall     = 1'b1;
        unique case (r_state)
            htmc_pkg::S_IDLE: begin
                o_stall     = 1'b0;
                n_scan_addr = '0;
                n_cmp_idx   = '0;
                n_res_found = 1'b0;
                n_res_index = '0;
                n_res_mark  = '0;
                if (in_acc) begin
                    if (i_mode == htmc_pkg::MODE_LOAD) begin
                        // write at the accepting edge
                        if (load_ok) begin
                            st_wr.key_en  = 1'b1;
                            st_wr.mark_en = 1'b1;
                            n_res_found   = 1'b1;
                            n_res_index   = i_entry_index;
                            n_res_mark    = i_given_mark;
                        end
                        n_state = htmc_pkg::S_DONE;
                    end else if (limit == '0) begin
                        n_state = htmc_pkg::S_DONE;
                    end else begin
                        n_state = htmc_pkg::S_READ;
                    end
                end
            end
            htmc_pkg::S_READ: begin
                n_scan_addr = r_scan_addr + AW'(1);
                n_state     = htmc_pkg::S_SCAN;
            end
            htmc_pkg::S_SCAN: begin
                st_wr_addr = r_cmp_idx;
                st_wr_mark = htmc_pkg::MARK_CLAIMED;
                if (hit) begin
                    n_res_found = 1'b1;
                    n_res_index = cmp_idx_w[htmc_pkg::INDEX_W-1:0];
                    n_res_mark  = st_rd_mark;
                    st_wr.mark_en = (r_mode == htmc_pkg::MODE_CLAIM);
                    n_state     = htmc_pkg::S_DONE;
                end else if (last) begin
                    n_state = htmc_pkg::S_DONE;
                end else begin
                    n_scan_addr = r_scan_addr + AW'(1);
                    n_cmp_idx   = r_cmp_idx + AW'(1);
                end
            end
            htmc_pkg::S_DONE: begin
                // hold until the output register frees up
                if (out_free) begin
                    n_state = htmc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = htmc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= htmc_pkg::S_IDLE;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_entry_count <= i_cfg_wr_data;
            end
            if (r_state == htmc_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_cmp_idx   <= n_cmp_idx;
        r_res_found <= n_res_found;
        r_res_index <= n_res_index;
        r_res_mark  <= n_res_mark;
        if (in_acc) begin
            r_mode <= i_mode;
            r_key  <= in_key;
            // claim looks for a free entry
            r_mark <= (i_mode == htmc_pkg::MODE_CLAIM) ? htmc_pkg::MARK_FREE : i_given_mark;
        end
        if (r_state == htmc_pkg::S_DONE && out_free) begin
            r_out_found <= r_res_found;
            r_out_index <= r_res_index;
            r_out_mark  <= r_res_mark;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_match_index = r_out_index;
    assign o_match_mark  = r_out_mark;

endmodule
`default_nettype wire

// File: design/htmc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htmc_checker
// Port-level checks of the hash table match and claim unit.
// ----------------------------------------------------------------------------
module htmc_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_valid,
    input wire                              o_stall,
    input wire                              o_valid,
    input wire                              i_stall,
    input wire                              o_found,
    input wire [htmc_pkg::INDEX_W-1:0]      o_match_index,
    input wire [htmc_pkg::MARK_W-1:0]       o_match_mark
);

    // a miss reports zero index and mark
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_match_index == '0 && o_match_mark == '0))
        else $error("miss with nonzero index or mark");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_found) && $stable(o_match_index) &&
             $stable(o_match_mark)))
        else $error("stalled result changed");

    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("accepted a second word while busy");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind hash_table_match_and_claim_unit htmc_checker u_htmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_found       (o_found),
    .o_match_index (o_match_index),
    .o_match_mark  (o_match_mark)
);
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key match and claim table.
// ----------------------------------------------------------------------------
// A short table of directed words covers the empty scan, the key extremes,
// lowest-slot priority, mark filtering, claim and a reclaim after reload.
// The random part then fills every slot and runs phases under several
// entry counts. Keys come mostly from a small pool, so hits, misses and
// claims stay frequent. Each word is predicted at acceptance and every
// result word is compared in order. Both sides idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [htmc_pkg::MODE_W-1:0]     mode;
        logic [htmc_pkg::KEY_HIGH_W-1:0] key_high;
        logic [htmc_pkg::KEY_MID_W-1:0]  key_mid;
        logic [htmc_pkg::KEY_LOW_W-1:0]  key_low;
        logic [htmc_pkg::INDEX_W-1:0]    index;
        logic [htmc_pkg::MARK_W-1:0]     mark;
    } t_word_in;

    typedef struct packed {
        logic                          found;
        logic [htmc_pkg::INDEX_W-1:0]  index;
        logic [htmc_pkg::MARK_W-1:0]   mark;
    } t_word_out;

    typedef struct {
        logic [htmc_pkg::COUNT_W-1:0] cnt;
        t_word_in                     w;
        bit                           chk;
        t_word_out                    typed;
    } t_row;

    localparam logic [htmc_pkg::KEY_W-1:0] KEY_ONES = '1;
    localparam logic [htmc_pkg::KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [htmc_pkg::KEY_W-1:0] KEY_A    = {32'hA5C3_0F96,
                                                       64'h0123_4567_89AB_CDEF,
                                                       64'hFEDC_BA98_7654_3210};
    localparam int NUM_PHASES  = 13;
    localparam int PHASE_WORDS = 105;
    localparam int HOLD_CYCLES = 300;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [htmc_pkg::COUNT_W-1:0]      i_cfg_wr_data = '0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic [htmc_pkg::MODE_W-1:0]       i_mode = htmc_pkg::MODE_LOAD;
    logic [htmc_pkg::KEY_HIGH_W-1:0]   i_key_high = '0;
    logic [htmc_pkg::KEY_MID_W-1:0]    i_key_mid = '0;
    logic [htmc_pkg::KEY_LOW_W-1:0]    i_key_low = '0;
    logic [htmc_pkg::INDEX_W-1:0]      i_entry_index = '0;
    logic [htmc_pkg::MARK_W-1:0]       i_given_mark = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic                              o_found;
    logic [htmc_pkg::INDEX_W-1:0]      o_match_index;
    logic [htmc_pkg::MARK_W-1:0]       o_match_mark;

    // Predictor copy of the slot store and the entry count
    logic [htmc_pkg::KEY_HIGH_W-1:0] tbl_key_high [htmc_pkg::CAPACITY_DEF];
    logic [htmc_pkg::KEY_MID_W-1:0]  tbl_key_mid  [htmc_pkg::CAPACITY_DEF];
    logic [htmc_pkg::KEY_LOW_W-1:0]  tbl_key_low  [htmc_pkg::CAPACITY_DEF];
    logic [htmc_pkg::MARK_W-1:0]     tbl_mark     [htmc_pkg::CAPACITY_DEF];
    logic [htmc_pkg::COUNT_W-1:0]    scan_count = '0;

    t_word_out pending_results [$];
    t_row      rows [$];
    logic [htmc_pkg::KEY_W-1:0] key_pool [8];

    int  errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_hits = 0;
    int  n_claims = 0;
    int  n_settings = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    bit  hold_req = 1'b0;

    hash_table_match_and_claim_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_key_high    (i_key_high),
        .i_key_mid     (i_key_mid),
        .i_key_low     (i_key_low),
        .i_entry_index (i_entry_index),
        .i_given_mark  (i_given_mark),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_match_index (o_match_index),
        .o_match_mark  (o_match_mark)
    );

    always #2 i_clk = ~i_clk;

    // Apply one word to the predicted store and return the result it gives
    function automatic t_word_out lookup_and_claim(input t_word_in w);
        t_word_out                   r;
        int                          lim;
        int                          i;
        logic [htmc_pkg::MARK_W-1:0] want_mark;
        r = '0;
        if (w.mode == htmc_pkg::MODE_LOAD) begin
            tbl_key_high[w.index] = w.key_high;
            tbl_key_mid[w.index]  = w.key_mid;
            tbl_key_low[w.index]  = w.key_low;
            tbl_mark[w.index]     = w.mark;
            r.found = 1'b1;
            r.index = w.index;
            r.mark  = w.mark;
            return r;
        end
        want_mark = (w.mode == htmc_pkg::MODE_CLAIM) ? htmc_pkg::MARK_FREE : w.mark;
        lim = (int'(scan_count) > htmc_pkg::CAPACITY_DEF) ? htmc_pkg::CAPACITY_DEF
                                                          : int'(scan_count);
        for (i = 0; i < lim; i++) begin
            if (!r.found && tbl_key_high[i] == w.key_high && tbl_key_mid[i] == w.key_mid &&
                tbl_key_low[i] == w.key_low &&
                (w.mode == htmc_pkg::MODE_ANY || tbl_mark[i] == want_mark)) begin
                r.found = 1'b1;
                r.index = i[htmc_pkg::INDEX_W-1:0];
                r.mark  = tbl_mark[i];
                if (w.mode == htmc_pkg::MODE_CLAIM) begin
                    tbl_mark[i] = htmc_pkg::MARK_CLAIMED;
                    n_claims++;
                end
            end
        end
        if (r.found)
            n_hits++;
        return r;
    endfunction

    function automatic void add_row(input int cnt, input logic [htmc_pkg::MODE_W-1:0] mode,
                                    input logic [htmc_pkg::KEY_W-1:0] key, input int idx,
                                    input int mark, input bit chk, input int ef,
                                    input int ei, input int em);
        t_row row;
        row.cnt          = cnt[htmc_pkg::COUNT_W-1:0];
        row.w.mode       = mode;
        row.w.key_high   = key[159:128];
        row.w.key_mid    = key[127:64];
        row.w.key_low    = key[63:0];
        row.w.index      = idx[htmc_pkg::INDEX_W-1:0];
        row.w.mark       = mark[htmc_pkg::MARK_W-1:0];
        row.chk          = chk;
        row.typed.found  = ef[0];
        row.typed.index  = ei[htmc_pkg::INDEX_W-1:0];
        row.typed.mark   = em[htmc_pkg::MARK_W-1:0];
        rows.push_back(row);
    endfunction

    // Offer one word, hold it until taken, then record what it should return
    task automatic send_word(input t_word_in w, input bit chk, input t_word_out typed);
        int        gap;
        t_word_out want;
        if (n_sent % 40 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= w.mode;
        i_key_high    <= w.key_high;
        i_key_mid     <= w.key_mid;
        i_key_low     <= w.key_low;
        i_entry_index <= w.index;
        i_given_mark  <= w.mark;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want = lookup_and_claim(w);
        if (chk)
            want = typed;
        pending_results.push_back(want);
        n_sent++;
    endtask

    // Drop valid and wait until every result is back and the unit is idle
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_count(input logic [htmc_pkg::COUNT_W-1:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        scan_count = value;
        n_settings++;
    endtask

    // Receiver: random stall before each result word, one long hold-off on request
    initial begin : drive_stall
        int gap;
        int turn;
        turn = 0;
        wait (i_rst_n);
        forever begin
            if (turn % 40 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            turn++;
            gap = rx_calm ? 0 : $urandom_range(0, 17);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_word_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: found %0d index %0d mark %0d",
                       o_found, o_match_index, o_match_mark);
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    errors++;
                end
                if (o_match_index !== want.index) begin
                    $error("match_index: expected %0d, got %0d", want.index, o_match_index);
                    errors++;
                end
                if (o_match_mark !== want.mark) begin
                    $error("match_mark: expected %0d, got %0d", want.mark, o_match_mark);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [htmc_pkg::COUNT_W-1:0] fixed_counts [7];
        logic [htmc_pkg::KEY_W-1:0]   key;
        t_word_in                     w;
        int                           ph;
        int                           n;
        int                           roll;
        fixed_counts = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd63, 7'd2, 7'd65};
        for (n = 0; n < 8; n++)
            key_pool[n] = {$urandom, $urandom, $urandom, $urandom, $urandom};

        // Count 0 scans nothing; loads report their own slot and mark
        add_row(0, htmc_pkg::MODE_ANY,   KEY_ONES,  0, 3, 1, 0, 0, 0);
        add_row(0, htmc_pkg::MODE_MARK,  KEY_ZERO, 63, 3, 1, 0, 0, 0);
        add_row(0, htmc_pkg::MODE_CLAIM, KEY_ZERO,  0, 0, 1, 0, 0, 0);
        add_row(0, htmc_pkg::MODE_LOAD,  KEY_ONES,  0, 3, 1, 1, 0, 3);
        add_row(0, htmc_pkg::MODE_LOAD,  KEY_ZERO, 63, 0, 1, 1, 63, 0);
        add_row(0, htmc_pkg::MODE_LOAD,  KEY_A,     1, 0, 1, 1, 1, 0);
        add_row(0, htmc_pkg::MODE_LOAD,  KEY_A,     2, 1, 1, 1, 2, 1);
        add_row(0, htmc_pkg::MODE_LOAD,  KEY_ZERO,  3, 2, 1, 1, 3, 2);
        add_row(0, htmc_pkg::MODE_ANY,   KEY_ONES,  0, 0, 1, 0, 0, 0);
        // Four slots live: priority, mark filter, claim and reclaim
        add_row(4, htmc_pkg::MODE_ANY,   KEY_ONES,  5, 2, 1, 1, 0, 3);
        add_row(4, htmc_pkg::MODE_ANY,   KEY_ONES ^ 160'd1, 0, 0, 0, 0, 0, 0);
        add_row(4, htmc_pkg::MODE_ANY,   KEY_A,     0, 0, 0, 0, 0, 0);
        add_row(4, htmc_pkg::MODE_MARK,  KEY_A,     0, 1, 0, 0, 0, 0);
        add_row(4, htmc_pkg::MODE_MARK,  KEY_A,     0, 3, 0, 0, 0, 0);
        add_row(4, htmc_pkg::MODE_CLAIM, KEY_A,     9, 3, 0, 0, 0, 0);
        add_row(4, htmc_pkg::MODE_CLAIM, KEY_A,     0, 0, 0, 0, 0, 0);
        add_row(4, htmc_pkg::MODE_ANY,   KEY_A,     0, 0, 0, 0, 0, 0);
        add_row(4, htmc_pkg::MODE_MARK,  KEY_A,     0, 2, 0, 0, 0, 0);
        add_row(4, htmc_pkg::MODE_MARK,  KEY_ONES,  0, 3, 1, 1, 0, 3);
        add_row(4, htmc_pkg::MODE_CLAIM, KEY_ZERO,  0, 0, 0, 0, 0, 0);
        add_row(4, htmc_pkg::MODE_LOAD,  KEY_A,     2, 0, 0, 0, 0, 0);
        add_row(4, htmc_pkg::MODE_CLAIM, KEY_A,     0, 0, 0, 0, 0, 0);
        // Count 1 hides the key in slot 1
        add_row(1, htmc_pkg::MODE_ANY,   KEY_A,     0, 0, 0, 0, 0, 0);
        add_row(1, htmc_pkg::MODE_ANY,   KEY_ONES,  0, 0, 0, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].cnt != scan_count)
                set_count(rows[r].cnt);
            send_word(rows[r].w, rows[r].chk, rows[r].typed);
        end

        // Load every slot so that any count only scans written entries
        for (n = 0; n < htmc_pkg::CAPACITY_DEF; n++) begin
            key          = key_pool[$urandom_range(0, 7)];
            w.mode       = htmc_pkg::MODE_LOAD;
            w.key_high   = key[159:128];
            w.key_mid    = key[127:64];
            w.key_low    = key[63:0];
            w.index      = n[htmc_pkg::INDEX_W-1:0];
            w.mark       = htmc_pkg::MARK_W'($urandom_range(0, 3));
            send_word(w, 1'b0, '0);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            set_count(ph < 7 ? fixed_counts[ph]
                             : htmc_pkg::COUNT_W'($urandom_range(0, 127)));
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (ph == 2 && n == 20)
                    hold_req = 1'b1;
                if (ph == 5 && n == 50)
                    wait_drained();
                roll = $urandom_range(0, 19);
                key  = key_pool[$urandom_range(0, 7)];
                if (roll >= 19)
                    key = {$urandom, $urandom, $urandom, $urandom, $urandom};
                else if (roll >= 17)
                    key = key ^ (160'd1 << $urandom_range(0, 159));
                w.mode     = htmc_pkg::MODE_W'($urandom_range(0, 3));
                w.key_high = key[159:128];
                w.key_mid  = key[127:64];
                w.key_low  = key[63:0];
                w.index    = htmc_pkg::INDEX_W'($urandom_range(0, 63));
                // lean toward free marks so claims keep finding slots
                w.mark     = ($urandom_range(0, 2) == 0) ? htmc_pkg::MARK_FREE
                                                         : htmc_pkg::MARK_W'($urandom_range(0, 3));
                send_word(w, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("tb: %0d words sent, %0d results checked, %0d search hits, %0d claims",
                 n_sent, n_checked, n_hits, n_claims);
        $display("tb: %0d entry count settings, extremes 0 and 127 included", n_settings);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #2400000;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
